@@ hdl/voltage_history_ring_stats_defines.svh @@
// Assertion macros shared by the voltage history ring stats RTL.
`ifndef VOLTAGE_HISTORY_RING_STATS_DEFINES_SVH
`define VOLTAGE_HISTORY_RING_STATS_DEFINES_SVH

`ifndef SYNTHESIS
`define VHRS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VHRS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VHRS_ASSERT(label, clk, rstn, prop, msg)
`define VHRS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hdl/vhrs_pkg.sv @@
// Package: widths, command codes and defaults for the voltage history ring stats block.
package vhrs_pkg;

    localparam int DEPTH_DEF = 256;

    localparam int CMD_W   = 2;
    localparam int VOLT_W  = 16;
    localparam int PIDX_W  = 12;
    localparam int SCNT_W  = 9;

    localparam logic [PIDX_W-1:0] CHART_POINTS_RST = 12'd128;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STATS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHART = 2'd2;

endpackage

@@ hdl/vhrs_mem.sv @@
// Sample history memory: one write port, one registered read port.
module vhrs_mem
    import vhrs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [VOLT_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [VOLT_W-1:0] rd_data
);

    logic [VOLT_W-1:0] mem [DEPTH];
    logic [VOLT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/vhrs_div.sv @@
// Bit-serial restoring divider used to scale chart point indexes.
module vhrs_div #(
    parameter int NUM_W = 24,
    parameter int DIV_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/voltage_history_ring_stats.sv @@
// Top level: ring history of battery voltages with stats and chart queries.
//
// Each input beat gives one result beat. A stats query reads every held
// sample from the history memory, one read a cycle; with an empty history
// it reads none. A chart query computes the sample position directly when the
// history fits the chart or the chart has a single point, otherwise it scales
// the point index with the serial divider, whose dividend is
// PIDX_W + clog2(DEPTH+1) + 2 bits wide; with no sample to give it reads none.
// One item is worked on at a time; a finished result waits in the output
// register while the next beat is taken. The history memory needs no clearing
// after reset.
`include "voltage_history_ring_stats_defines.svh"

module voltage_history_ring_stats
    import vhrs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [PIDX_W-1:0] cfg_wdata,    // chart_points
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,      // voltage_hundredths[15:0], point_index[27:16]
    input  logic [1:0]        s_tuser,      // cmd[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,      // sample_count[8:0], point_voltage[24:9],
                                            // min_voltage[40:25], max_voltage[56:41]
    output logic [0:0]        m_tuser       // value_valid[0]
);

    localparam int AW     = $clog2(DEPTH);
    localparam int FC_W   = $clog2(DEPTH + 1);
    localparam int CW     = (FC_W > PIDX_W ? FC_W : PIDX_W) + 1;
    localparam int PROD_W = PIDX_W + FC_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DIV_W  = PIDX_W + 1;

    localparam logic [AW:0]     DEPTH_EXT = (AW + 1)'(DEPTH);
    localparam logic [FC_W-1:0] DEPTH_FC  = FC_W'(DEPTH);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_WALK   = 9'b000000010,
        ST_CMUL   = 9'b000000100,
        ST_CSTART = 9'b000001000,
        ST_CDIV   = 9'b000010000,
        ST_CADDR  = 9'b000100000,
        ST_CREAD  = 9'b001000000,
        ST_CCAP   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_EXT) begin
            s = s - DEPTH_EXT;
        end
        return s[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [PIDX_W-1:0] cp_reg, cp_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [FC_W-1:0]   cnt_reg, cnt_next;
    logic              rvalid_reg, rvalid_next;
    logic              first_reg, first_next;
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic              res_vv_reg, res_vv_next;
    logic [VOLT_W-1:0] res_pv_reg, res_pv_next;
    logic [VOLT_W-1:0] res_mn_reg, res_mn_next;
    logic [VOLT_W-1:0] res_mx_reg, res_mx_next;
    logic              m_valid_reg, m_valid_next;
    logic [SCNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic              m_vv_reg, m_vv_next;
    logic [VOLT_W-1:0] m_pv_reg, m_pv_next;
    logic [VOLT_W-1:0] m_mn_reg, m_mn_next;
    logic [VOLT_W-1:0] m_mx_reg, m_mx_next;

    logic [CMD_W-1:0]  in_cmd;
    logic [VOLT_W-1:0] in_volt;
    logic [PIDX_W-1:0] in_pidx;
    logic              accept;

    logic [AW:0]       old_sum;
    logic [AW-1:0]     oldest;
    logic [CW-1:0]     fc_cw, cp_cw, pidx_cw, lead_sum, lead_pos;
    logic [FC_W+SCNT_W-1:0] fc_ext;

    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [VOLT_W-1:0] mem_rd_data;

    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic [NUM_W-1:0]  div_quotient;

    assign in_cmd  = s_tuser[CMD_W-1:0];
    assign in_volt = s_tdata[VOLT_W-1:0];
    assign in_pidx = s_tdata[VOLT_W+PIDX_W-1:VOLT_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign old_sum = {1'b0, wp_reg} + DEPTH_EXT - (AW + 1)'(fc_reg);
    assign oldest  = (old_sum >= DEPTH_EXT) ? AW'(old_sum - DEPTH_EXT) : old_sum[AW-1:0];

    assign fc_cw    = CW'(fc_reg);
    assign cp_cw    = CW'(cp_reg);
    assign pidx_cw  = CW'(in_pidx);
    assign lead_sum = pidx_cw + fc_cw;
    assign lead_pos = lead_sum - cp_cw;
    assign fc_ext   = (FC_W + SCNT_W)'(fc_reg);

    assign mem_wr_en = accept && (in_cmd == CMD_ADD);

    assign div_start    = (state_reg == ST_CSTART);
    assign div_dividend = NUM_W'({prod_reg, 1'b0}) + NUM_W'(cp_reg - 1'b1);
    assign div_divisor  = {cp_reg - 1'b1, 1'b0};

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = slot_reg;
        case (state_reg)
            ST_WALK:  mem_rd_en = (cnt_reg != fc_reg);
            ST_CREAD: mem_rd_en = 1'b1;
            default:  mem_rd_en = 1'b0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        fc_next      = fc_reg;
        cp_next      = cfg_we ? cfg_wdata : cp_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        rvalid_next  = 1'b0;
        first_next   = first_reg;
        pidx_next    = pidx_reg;
        prod_next    = prod_reg;
        pos_next     = pos_reg;
        res_vv_next  = res_vv_reg;
        res_pv_next  = res_pv_reg;
        res_mn_next  = res_mn_reg;
        res_mx_next  = res_mx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_cnt_next   = m_cnt_reg;
        m_vv_next    = m_vv_reg;
        m_pv_next    = m_pv_reg;
        m_mn_next    = m_mn_reg;
        m_mx_next    = m_mx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_vv_next = 1'b0;
                    res_pv_next = '0;
                    res_mn_next = '0;
                    res_mx_next = '0;
                    pidx_next   = in_pidx;
                    state_next  = ST_DONE;
                    case (in_cmd)
                        CMD_ADD: begin
                            wp_next = add_wrap(wp_reg, AW'(1));
                            if (fc_reg != DEPTH_FC) begin
                                fc_next = fc_reg + 1'b1;
                            end
                        end
                        CMD_STATS: begin
                            if (fc_reg != '0) begin
                                slot_next  = oldest;
                                cnt_next   = '0;
                                first_next = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        CMD_CHART: begin
                            if (fc_reg != '0 && cp_reg != '0 && in_pidx < cp_reg) begin
                                if (fc_cw <= cp_cw) begin
                                    if (lead_sum >= cp_cw) begin
                                        pos_next   = lead_pos[AW-1:0];
                                        state_next = ST_CADDR;
                                    end
                                end else if (cp_reg == PIDX_W'(1)) begin
                                    pos_next   = AW'(fc_reg - 1'b1);
                                    state_next = ST_CADDR;
                                end else begin
                                    state_next = ST_CMUL;
                                end
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK: begin
                if (mem_rd_en) begin
                    slot_next = add_wrap(slot_reg, AW'(1));
                    cnt_next  = cnt_reg + 1'b1;
                end
                rvalid_next = mem_rd_en;
                if (rvalid_reg) begin
                    first_next  = 1'b0;
                    res_pv_next = mem_rd_data;
                    if (first_reg || mem_rd_data < res_mn_reg) begin
                        res_mn_next = mem_rd_data;
                    end
                    if (first_reg || mem_rd_data > res_mx_reg) begin
                        res_mx_next = mem_rd_data;
                    end
                    if (!mem_rd_en) begin
                        res_vv_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_CMUL: begin
                prod_next  = PROD_W'(pidx_reg) * PROD_W'(fc_reg - 1'b1);
                state_next = ST_CSTART;
            end
            ST_CSTART: state_next = ST_CDIV;
            ST_CDIV: begin
                if (div_done) begin
                    if (div_quotient >= NUM_W'(fc_reg)) begin
                        pos_next = AW'(fc_reg - 1'b1);
                    end else begin
                        pos_next = div_quotient[AW-1:0];
                    end
                    state_next = ST_CADDR;
                end
            end
            ST_CADDR: begin
                slot_next  = add_wrap(oldest, pos_reg);
                state_next = ST_CREAD;
            end
            ST_CREAD: state_next = ST_CCAP;
            ST_CCAP: begin
                res_vv_next = 1'b1;
                res_pv_next = mem_rd_data;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_cnt_next   = fc_ext[SCNT_W-1:0];
                    m_vv_next    = res_vv_reg;
                    m_pv_next    = res_pv_reg;
                    m_mn_next    = res_mn_reg;
                    m_mx_next    = res_mx_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fc_reg      <= '0;
            cp_reg      <= CHART_POINTS_RST;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fc_reg      <= fc_next;
            cp_reg      <= cp_next;
            rvalid_reg  <= rvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        cnt_reg    <= cnt_next;
        first_reg  <= first_next;
        pidx_reg   <= pidx_next;
        prod_reg   <= prod_next;
        pos_reg    <= pos_next;
        res_vv_reg <= res_vv_next;
        res_pv_reg <= res_pv_next;
        res_mn_reg <= res_mn_next;
        res_mx_reg <= res_mx_next;
        m_cnt_reg  <= m_cnt_next;
        m_vv_reg   <= m_vv_next;
        m_pv_reg   <= m_pv_next;
        m_mn_reg   <= m_mn_next;
        m_mx_reg   <= m_mx_next;
    end

    vhrs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wp_reg),
        .wr_data (in_volt),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    vhrs_div #(
        .NUM_W (NUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {7'b0, m_mx_reg, m_mn_reg, m_pv_reg, m_cnt_reg};
    assign m_tuser[0] = m_vv_reg;

    `VHRS_ASSERT(a_no_rw_overlap, aclk, aresetn, !(mem_wr_en && mem_rd_en), "history read and write in the same cycle")
    `VHRS_ASSERT(a_fill_bound, aclk, aresetn, fc_reg <= DEPTH_FC, "fill count above depth")
    `VHRS_ASSERT(a_walk_bound, aclk, aresetn, (state_reg == ST_WALK) |-> (cnt_reg <= fc_reg), "stats walk read past held samples")
    `VHRS_ASSERT(a_div_done_state, aclk, aresetn, div_done |-> (state_reg == ST_CDIV), "divider finished outside chart divide")

endmodule
